[design/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and codes of the byte deque: opcodes, status codes, the
// sequencer state and the status pair handed to the output stage
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_INSERT     = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OOB   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_SH_RD,
    S_SH_WR,
    S_FINISH
  } state_e;

  typedef struct packed {
    status_e status;
    status_e last_error;
  } flags_t;

endpackage

[design/bdq_in_if.sv]
// ----------------------------------------------------------------------------
// bdq_in_if
// command channel of the byte deque: opcode, logical index and data byte
// ----------------------------------------------------------------------------
interface bdq_in_if #(
  parameter int unsigned CNT_W = 7
) ();

  logic             valid;
  logic             ready;
  logic [2:0]       opcode;
  logic [CNT_W-1:0] index;
  logic [7:0]       data_in;

  modport source (output valid, output opcode, output index, output data_in, input ready);
  modport sink   (input valid, input opcode, input index, input data_in, output ready);

endinterface

[design/bdq_out_if.sv]
// ----------------------------------------------------------------------------
// bdq_out_if
// result channel of the byte deque: data byte, fill count and status
// ----------------------------------------------------------------------------
interface bdq_out_if #(
  parameter int unsigned CNT_W = 7
) ();

  logic             valid;
  logic             ready;
  logic [7:0]       read_data;
  logic [CNT_W-1:0] count;
  logic [1:0]       status;
  logic [1:0]       last_error;

  modport source (
    output valid, output read_data, output count, output status, output last_error,
    input ready
  );
  modport sink (
    input valid, input read_data, input count, input status, input last_error,
    output ready
  );

endinterface

[design/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// generic simple dual port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// sequencer of the byte deque: decodes one command, drives the store ram,
// runs the insert shift, a read state then a write state per moved byte, and holds the result
// ----------------------------------------------------------------------------
module bdq_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned PTR_W    = $clog2(CAPACITY),
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bdq_in_if.sink               in_i,
  // store ram
  output logic                 ram_we_o,
  output logic [PTR_W-1:0]     ram_waddr_o,
  output logic [7:0]           ram_wdata_o,
  output logic                 ram_re_o,
  output logic [PTR_W-1:0]     ram_raddr_o,
  input  logic [7:0]           ram_rdata_i,
  // result towards the output register
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [7:0]           res_data_o,
  output logic [CNT_W-1:0]     res_count_o,
  output bdq_pkg::flags_t      res_flags_o
);

  import bdq_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] CapSum  = SUM_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CapCnt  = CNT_W'(CAPACITY);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(CAPACITY - 1);

  state_e           state_q, state_d;
  logic [2:0]       op_q;
  logic [CNT_W-1:0] idx_q;
  logic [7:0]       din_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          err_q, err_d;
  status_e          st_q, st_d;
  logic [7:0]       rd_q, rd_d;
  logic [PTR_W-1:0] src_q, src_d;
  logic [PTR_W-1:0] dst_q, dst_d;
  logic             fwd_q, fwd_d;
  logic [CNT_W-1:0] n_q, n_d;

  logic             full;
  logic             empty;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] tail_slot;
  logic [CNT_W-1:0] back_len;

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= CapSum) begin
      sum = sum - CapSum;
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LastPtr : p - PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LastPtr) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count_q == CapCnt);
  assign empty     = (count_q == '0);
  assign head_dec  = ptr_dec(head_q);
  assign tail_slot = slot_of(head_q, count_q);
  assign back_len  = count_q - idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  // command and working registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q  <= in_i.opcode;
      idx_q <= in_i.index;
      din_q <= in_i.data_in;
    end
    st_q  <= st_d;
    rd_q  <= rd_d;
    src_q <= src_d;
    dst_q <= dst_d;
    fwd_q <= fwd_d;
    n_q   <= n_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    err_d       = err_q;
    st_d        = st_q;
    rd_d        = rd_q;
    src_d       = src_q;
    dst_d       = dst_q;
    fwd_d       = fwd_q;
    n_d         = n_q;
    in_i.ready  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = dst_q;
    ram_wdata_o = din_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = src_q;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        st_d    = ST_OK;
        rd_d    = '0;
        state_d = S_FINISH;
        case (op_e'(op_q))
          OP_PUSH_FRONT: begin
            if (full) begin
              st_d = ST_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = head_dec;
              head_d      = head_dec;
              count_d     = count_q + CNT_W'(1);
            end
          end
          OP_PUSH_BACK: begin
            if (full) begin
              st_d = ST_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = tail_slot;
              count_d     = count_q + CNT_W'(1);
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              st_d = ST_EMPTY;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = head_q;
              head_d      = ptr_inc(head_q);
              count_d     = count_q - CNT_W'(1);
              state_d     = S_RDWAIT;
            end
          end
          OP_POP_BACK: begin
            if (empty) begin
              st_d = ST_EMPTY;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = slot_of(head_q, count_q - CNT_W'(1));
              count_d     = count_q - CNT_W'(1);
              state_d     = S_RDWAIT;
            end
          end
          OP_READ: begin
            if (idx_q >= count_q) begin
              st_d = ST_OOB;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = slot_of(head_q, idx_q);
              state_d     = S_RDWAIT;
            end
          end
          OP_WRITE: begin
            if (idx_q >= count_q) begin
              st_d = ST_OOB;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = slot_of(head_q, idx_q);
            end
          end
          OP_INSERT: begin
            if (idx_q > count_q) begin
              st_d = ST_OOB;
            end else if (full) begin
              st_d = ST_FULL;
            end else begin
              count_d = count_q + CNT_W'(1);
              state_d = S_SH_RD;
              if (back_len > (count_q >> 1)) begin
                // front part moves one slot towards the front
                head_d = head_dec;
                dst_d  = head_dec;
                src_d  = head_q;
                fwd_d  = 1'b1;
                n_d    = idx_q;
              end else begin
                // back part moves one slot towards the back
                dst_d  = tail_slot;
                src_d  = ptr_dec(tail_slot);
                fwd_d  = 1'b0;
                n_d    = back_len;
              end
            end
          end
          default: begin
          end
        endcase
        if (st_d != ST_OK) begin
          err_d = st_d;
        end
      end

      S_RDWAIT: begin
        rd_d    = ram_rdata_i;
        state_d = S_FINISH;
      end

      S_SH_RD: begin
        if (n_q == '0) begin
          ram_we_o = 1'b1;
          state_d  = S_FINISH;
        end else begin
          ram_re_o = 1'b1;
          state_d  = S_SH_WR;
        end
      end

      S_SH_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i;
        dst_d       = src_q;
        src_d       = fwd_q ? ptr_inc(src_q) : ptr_dec(src_q);
        n_d         = n_q - CNT_W'(1);
        state_d     = S_SH_RD;
      end

      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_data_o             = rd_q;
  assign res_count_o            = count_q;
  assign res_flags_o.status     = st_q;
  assign res_flags_o.last_error = err_q;

endmodule

[design/byte_deque_with_insert.sv]
// sequence: every command passes accept, decode and finish; pop and read add a read wait,
// insert adds a read state and a write state per byte moved, n = bytes moved (at most CAPACITY/2)
// one command in flight; the store ram gives one read and one write per cycle,
// and each moved byte takes a shift read state and a shift write state
// reset: head, count and sticky error cleared, store contents undefined, no clearing pass
// ----------------------------------------------------------------------------
// byte_deque_with_insert
// bounded double-ended byte buffer with indexed read, write and insert,
// store held in one synchronous ram
// ----------------------------------------------------------------------------
module byte_deque_with_insert #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bdq_in_if.sink   in_i,
  bdq_out_if.source out_o
);

  import bdq_pkg::*;

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // ram port between sequencer and store
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // finished result from the sequencer
  logic             res_valid;
  logic             res_ready;
  logic [7:0]       res_data;
  logic [CNT_W-1:0] res_count;
  flags_t           res_flags;

  // output register
  logic             out_valid_q;
  logic [7:0]       out_data_q;
  logic [CNT_W-1:0] out_count_q;
  flags_t           out_flags_q;
  logic             res_load;

  // sequencer: decode, pointer arithmetic and the insert shift
  bdq_ctrl #(
    .CAPACITY (CAPACITY),
    .PTR_W    (PTR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .res_count_o (res_count),
    .res_flags_o (res_flags)
  );

  // circular byte store, physical slot = (head + logical index) mod capacity
  bdq_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the output register parts the result beat from the command side, so the
  // sequencer goes back to idle as soon as its result is parked here
  assign res_ready = !out_valid_q || out_o.ready;
  assign res_load  = res_valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q  <= res_data;
      out_count_q <= res_count;
      out_flags_q <= res_flags;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = out_data_q;
  assign out_o.count      = out_count_q;
  assign out_o.status     = out_flags_q.status;
  assign out_o.last_error = out_flags_q.last_error;

endmodule

[design/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks of the byte deque, bound to the top level
// ----------------------------------------------------------------------------
module bdq_checker #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [7:0]       read_data_i,
  input logic [CNT_W-1:0] count_i,
  input logic [1:0]       status_i,
  input logic [1:0]       last_error_i
);

  import bdq_pkg::*;

  // one command at a time: no beat taken in the cycle after a beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("command beat taken while previous one still in work");

  // a push or insert refused as full only happens with the buffer full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_FULL) |-> (count_i == CNT_W'(CAPACITY)))
    else $error("full status with buffer not full");

  // sticky error follows every failing beat
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_OK) |-> (last_error_i == status_i))
    else $error("last error does not track status");

  // failed operations return zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_OK) |-> (read_data_i == 8'd0))
    else $error("nonzero data on failing beat");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(read_data_i) && $stable(count_i)
       && $stable(status_i) && $stable(last_error_i)))
    else $error("result beat changed while stalled");

endmodule

bind byte_deque_with_insert bdq_checker #(
  .CAPACITY (CAPACITY)
) u_bdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .read_data_i  (out_o.read_data),
  .count_i      (out_o.count),
  .status_i     (out_o.status),
  .last_error_i (out_o.last_error)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte deque: a short table of directed commands
// covering empty, full, out-of-range and both insert shift directions, then
// random command streams biased to fill and drain the store in turn; every
// reply is compared field by field against an in-bench shadow of the deque
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned IDX_MAX      = 127;
  localparam int unsigned HALF_PERIOD  = 2;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned RANDOM_BEATS = 750;
  localparam int unsigned MAX_GAP      = 16;
  // margin after the last expected reply, to catch any straggler beat
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 100;

  // opcode 7 has no enum member, the deque treats it as a no-op
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  // table rows either carry a hand-typed reply or defer to the shadow
  localparam bit KNOWN   = 1'b1;
  localparam bit PREDICT = 1'b0;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  count;
    status_e           status;
    status_e           last_error;
  } reply_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CNT_W-1:0]    index;
    logic [DATA_W-1:0]   data;
  } command_t;

  // repeats > 1 issues the same command with the data byte counting up
  typedef struct packed {
    command_t         cmd;
    logic [CNT_W-1:0] repeats;
    bit               known;
    reply_t           want;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 31;

  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // empty deque: pops, reads, writes and an insert past the end all fail
    '{'{OP_POP_FRONT,  7'd0,   8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd0,  ST_EMPTY, ST_EMPTY}},
    '{'{OP_POP_BACK,   7'd0,   8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd0,  ST_EMPTY, ST_EMPTY}},
    '{'{OP_READ,       7'd0,   8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd0,  ST_OOB,   ST_OOB}},
    '{'{OP_WRITE,      7'd0,   8'h3c}, 7'd1,  KNOWN,   '{8'h00, 7'd0,  ST_OOB,   ST_OOB}},
    '{'{OP_INSERT,     7'd1,   8'h3c}, 7'd1,  KNOWN,   '{8'h00, 7'd0,  ST_OOB,   ST_OOB}},
    // insert at index equal to the count appends
    '{'{OP_INSERT,     7'd0,   8'hff}, 7'd1,  KNOWN,   '{8'h00, 7'd1,  ST_OK,    ST_OOB}},
    '{'{OP_UNUSED,     7'd5,   8'h12}, 7'd1,  KNOWN,   '{8'h00, 7'd1,  ST_OK,    ST_OOB}},
    // push front with the head at slot 0 wraps it round
    '{'{OP_PUSH_FRONT, 7'd0,   8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd2,  ST_OK,    ST_OOB}},
    '{'{OP_PUSH_BACK,  7'd0,   8'ha5}, 7'd1,  KNOWN,   '{8'h00, 7'd3,  ST_OK,    ST_OOB}},
    '{'{OP_READ,       7'd0,   8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd3,  ST_OK,    ST_OOB}},
    '{'{OP_READ,       7'd2,   8'h00}, 7'd1,  KNOWN,   '{8'ha5, 7'd3,  ST_OK,    ST_OOB}},
    '{'{OP_READ,       7'd127, 8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd3,  ST_OOB,   ST_OOB}},
    '{'{OP_WRITE,      7'd1,   8'h5a}, 7'd1,  KNOWN,   '{8'h00, 7'd3,  ST_OK,    ST_OOB}},
    // front part shifts, then back part shifts
    '{'{OP_INSERT,     7'd1,   8'h11}, 7'd1,  PREDICT, '0},
    '{'{OP_INSERT,     7'd3,   8'h22}, 7'd1,  PREDICT, '0},
    '{'{OP_READ,       7'd64,  8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd5,  ST_OOB,   ST_OOB}},
    '{'{OP_POP_FRONT,  7'd0,   8'h00}, 7'd1,  PREDICT, '0},
    '{'{OP_POP_BACK,   7'd0,   8'h00}, 7'd1,  PREDICT, '0},
    // fill to capacity
    '{'{OP_PUSH_BACK,  7'd0,   8'h80}, 7'd61, PREDICT, '0},
    '{'{OP_PUSH_FRONT, 7'd0,   8'h77}, 7'd1,  KNOWN,   '{8'h00, 7'd64, ST_FULL,  ST_FULL}},
    '{'{OP_PUSH_BACK,  7'd0,   8'h77}, 7'd1,  KNOWN,   '{8'h00, 7'd64, ST_FULL,  ST_FULL}},
    '{'{OP_INSERT,     7'd64,  8'h77}, 7'd1,  KNOWN,   '{8'h00, 7'd64, ST_FULL,  ST_FULL}},
    // range check wins over the full check
    '{'{OP_INSERT,     7'd65,  8'h77}, 7'd1,  KNOWN,   '{8'h00, 7'd64, ST_OOB,   ST_OOB}},
    '{'{OP_READ,       7'd63,  8'h00}, 7'd1,  PREDICT, '0},
    '{'{OP_POP_FRONT,  7'd0,   8'h00}, 7'd1,  PREDICT, '0},
    '{'{OP_INSERT,     7'd0,   8'hc3}, 7'd1,  PREDICT, '0},
    '{'{OP_POP_BACK,   7'd0,   8'h00}, 7'd1,  PREDICT, '0},
    // widest back shift: 31 bytes move
    '{'{OP_INSERT,     7'd32,  8'h3c}, 7'd1,  PREDICT, '0},
    '{'{OP_WRITE,      7'd63,  8'hff}, 7'd1,  PREDICT, '0},
    '{'{OP_POP_FRONT,  7'd0,   8'h00}, 7'd64, PREDICT, '0},
    '{'{OP_POP_BACK,   7'd0,   8'h00}, 7'd1,  KNOWN,   '{8'h00, 7'd0,  ST_EMPTY, ST_EMPTY}}
  };

  logic clk = 1'b0;
  logic rst_n;

  bdq_in_if  #(.CNT_W(CNT_W)) cmd_if   ();
  bdq_out_if #(.CNT_W(CNT_W)) reply_if ();

  byte_deque_with_insert #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (reply_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // shadow of the deque: store, head slot, fill and sticky error
  logic [DATA_W-1:0] mirror [CAPACITY];
  int unsigned       mirror_head;
  int unsigned       mirror_fill;
  status_e           mirror_sticky;

  reply_t      expected_replies [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;   // no idling on either side while set
  bit          filling = 1'b1;  // random stream leans towards pushes while set

  function automatic int unsigned slot_at(int unsigned logical);
    return (mirror_head + logical) % CAPACITY;
  endfunction

  // applies one command to the shadow and returns the reply it gives
  function automatic reply_t apply_command(command_t c);
    reply_t      r;
    int unsigned k;
    r = '{read_data: '0, count: '0, status: ST_OK, last_error: ST_OK};
    case (c.opcode)
      OP_PUSH_FRONT: begin
        if (mirror_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          mirror_head = (mirror_head + CAPACITY - 1) % CAPACITY;
          mirror[mirror_head] = c.data;
          mirror_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (mirror_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          mirror[slot_at(mirror_fill)] = c.data;
          mirror_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = mirror[mirror_head];
          mirror_head = slot_at(1);
          mirror_fill--;
        end
      end
      OP_POP_BACK: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          mirror_fill--;
          r.read_data = mirror[slot_at(mirror_fill)];
        end
      end
      OP_READ: begin
        if (c.index >= mirror_fill) r.status = ST_OOB;
        else r.read_data = mirror[slot_at(c.index)];
      end
      OP_WRITE: begin
        if (c.index >= mirror_fill) r.status = ST_OOB;
        else mirror[slot_at(c.index)] = c.data;
      end
      OP_INSERT: begin
        if (c.index > mirror_fill) begin
          r.status = ST_OOB;
        end else if (mirror_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if ((mirror_fill - c.index) > mirror_fill / 2) begin
            // head part moves one slot towards the front
            mirror_head = (mirror_head + CAPACITY - 1) % CAPACITY;
            for (k = 0; k < c.index; k++) mirror[slot_at(k)] = mirror[slot_at(k + 1)];
          end else begin
            // tail part moves one slot towards the back
            for (k = mirror_fill; k > c.index; k--) mirror[slot_at(k)] = mirror[slot_at(k - 1)];
          end
          mirror[slot_at(c.index)] = c.data;
          mirror_fill++;
        end
      end
      default: ;
    endcase
    if (r.status != ST_OK) mirror_sticky = r.status;
    r.count      = mirror_fill[CNT_W-1:0];
    r.last_error = mirror_sticky;
    return r;
  endfunction

  function automatic int unsigned idle_cycles();
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // random command: mostly sensible indices, phases of filling and draining,
  // and a little noise with any opcode and any index
  function automatic command_t next_command();
    command_t    c;
    int unsigned pick;
    c.data = DATA_W'($urandom_range(0, 255));
    if (mirror_fill == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
    else if (mirror_fill == 0) filling = 1'b1;
    else if ($urandom_range(0, 39) == 0) filling = !filling;
    if ($urandom_range(0, 99) < 3) begin
      c.opcode = OPCODE_W'($urandom_range(0, 7));
      c.index  = CNT_W'($urandom_range(0, IDX_MAX));
      return c;
    end
    pick = $urandom_range(0, 99);
    if (filling) begin
      c.opcode = pick < 30 ? OP_PUSH_BACK : pick < 50 ? OP_PUSH_FRONT :
                 pick < 70 ? OP_INSERT    : pick < 75 ? OP_POP_FRONT  :
                 pick < 80 ? OP_POP_BACK  : pick < 90 ? OP_READ : OP_WRITE;
    end else begin
      c.opcode = pick < 35 ? OP_POP_FRONT : pick < 65 ? OP_POP_BACK  :
                 pick < 70 ? OP_PUSH_BACK : pick < 75 ? OP_PUSH_FRONT :
                 pick < 80 ? OP_INSERT    : pick < 90 ? OP_READ : OP_WRITE;
    end
    case (c.opcode)
      OP_READ, OP_WRITE: begin
        if (mirror_fill != 0 && $urandom_range(0, 9) != 0)
          c.index = CNT_W'($urandom_range(0, mirror_fill - 1));
        else c.index = CNT_W'($urandom_range(mirror_fill, CAPACITY));
      end
      OP_INSERT: begin
        if ($urandom_range(0, 9) != 0) c.index = CNT_W'($urandom_range(0, mirror_fill));
        else c.index = CNT_W'($urandom_range(mirror_fill, CAPACITY));
      end
      default: c.index = CNT_W'($urandom_range(0, IDX_MAX));
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // drives one command beat; valid stays high when the next beat follows at once
  task automatic issue(input command_t c, input bit known, input reply_t want);
    int unsigned gap;
    reply_t      predicted;
    gap = idle_cycles();
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.opcode  <= c.opcode;
    cmd_if.index   <= c.index;
    cmd_if.data_in <= c.data;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predicted = apply_command(c);
    expected_replies.insert(expected_replies.size(), known ? want : predicted);
    @(negedge clk);
  endtask

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // reply side: random stalls on ready, every beat checked against the oldest expectation
  initial begin : reply_sink
    int unsigned gap;
    reply_t      want;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = idle_cycles();
      if (gap != 0) begin
        reply_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      reply_if.ready <= 1'b1;
      @(posedge clk);
      while (!reply_if.valid) @(posedge clk);
      if (expected_replies.size() == 0) begin
        report_mismatch("reply beat with nothing outstanding");
      end else begin
        want = expected_replies[0];
        expected_replies.delete(0);
        if (reply_if.read_data !== want.read_data)
          report_mismatch($sformatf("read_data: got %0d, expected %0d",
                                    reply_if.read_data, want.read_data));
        if (reply_if.count !== want.count)
          report_mismatch($sformatf("count: got %0d, expected %0d",
                                    reply_if.count, want.count));
        if (reply_if.status !== want.status)
          report_mismatch($sformatf("status: got %0d, expected %0d",
                                    reply_if.status, want.status));
        if (reply_if.last_error !== want.last_error)
          report_mismatch($sformatf("last_error: got %0d, expected %0d",
                                    reply_if.last_error, want.last_error));
      end
      @(negedge clk);
    end
  end

  initial begin : command_source
    command_t    c;
    int unsigned row;
    int unsigned k;
    int unsigned n;
    rst_n          = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.opcode  = '0;
    cmd_if.index   = '0;
    cmd_if.data_in = '0;
    reply_if.ready = 1'b0;
    mirror_head    = 0;
    mirror_fill    = 0;
    mirror_sticky  = ST_OK;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (row = 0; row < PLAN_ROWS; row++) begin
      for (k = 0; k < DIRECTED_PLAN[row].repeats; k++) begin
        c      = DIRECTED_PLAN[row].cmd;
        c.data = DIRECTED_PLAN[row].cmd.data + DATA_W'(k);
        issue(c, DIRECTED_PLAN[row].known, DIRECTED_PLAN[row].want);
      end
    end

    // random stream, with the odd stretch where neither side idles
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      issue(next_command(), PREDICT, '0);
    end
    cmd_if.valid <= 1'b0;
    steady = 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
